@@ hw/rtl/tlb_fully_assoc_fifo_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the fully associative translation buffer
// Shared property forms, clocked on clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef TLB_FULLY_ASSOC_FIFO_UNIT_DEFINES_SVH
`define TLB_FULLY_ASSOC_FIFO_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TLBFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TLBFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tlbfa_pkg.sv @@
// ---------------------------------------------------------------------------
// tlbfa_pkg
// Field widths, operation codes and the cell-to-cell link word.
// ---------------------------------------------------------------------------
package tlbfa_pkg;

  localparam int unsigned PROC_W  = 8;
  localparam int unsigned PAGE_W  = 20;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned SLOT_W  = 4;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } op_t;

  // Lookup token moving down the row of cells.
  typedef struct packed {
    logic               tok;
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } link_t;

endpackage

@@ hw/rtl/tlbfa_cell.sv @@
// ---------------------------------------------------------------------------
// tlbfa_cell
// One buffer entry: holds the tag and frame, compares the passing lookup
// token against it and hands the token on to the next cell.
// ---------------------------------------------------------------------------
module tlbfa_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [tlbfa_pkg::PROC_W-1:0]  wr_process,
  input  logic [tlbfa_pkg::PAGE_W-1:0]  wr_page,
  input  logic [tlbfa_pkg::FRAME_W-1:0] wr_frame,
  input  logic [tlbfa_pkg::PROC_W-1:0]  key_process,
  input  logic [tlbfa_pkg::PAGE_W-1:0]  key_page,
  input  tlbfa_pkg::link_t             link_in,
  output tlbfa_pkg::link_t             link_out
);

  logic                         valid;
  logic [tlbfa_pkg::PROC_W-1:0]  entry_process;
  logic [tlbfa_pkg::PAGE_W-1:0]  entry_page;
  logic [tlbfa_pkg::FRAME_W-1:0] entry_frame;
  logic                         match;
  tlbfa_pkg::link_t             link_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_process <= wr_process;
      entry_page    <= wr_page;
      entry_frame   <= wr_frame;
    end
  end

  assign match = valid && (entry_process == key_process) && (entry_page == key_page);

  // A later cell overrides an earlier one, so the highest index wins.
  always_comb begin
    link_next.tok   = link_in.tok;
    link_next.hit   = link_in.hit | match;
    link_next.frame = match ? entry_frame : link_in.frame;
  end

  always_ff @(posedge clk) begin
    link_out.hit   <= link_next.hit;
    link_out.frame <= link_next.frame;
    if (rst) begin
      link_out.tok <= 1'b0;
    end else begin
      link_out.tok <= link_next.tok;
    end
  end

endmodule

@@ hw/rtl/tlb_fully_assoc_fifo_unit.sv @@
// ---------------------------------------------------------------------------
// tlb_fully_assoc_fifo_unit
// Fully associative translation buffer with first-in, first-out refill,
// built as a row of entry cells that a lookup token walks through.
// ---------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_ready   | op, process_id, page_number, frame_in
//  out     | out_valid / out_ready | hit, frame_out, slot_written
//
//  Fill: written in the accept cycle, result valid in the following cycle.
//  Lookup: the token passes the head register, each cell, then the output register;
//    it steps one cell per cycle, so the row length sets the lookup time.
//  One word is in flight at a time; in_ready also waits for the output
//    register to be free or being taken.
//  Reset clears all entry valid bits and the fill pointer.
// ---------------------------------------------------------------------------
`include "tlb_fully_assoc_fifo_unit_defines.svh"

module tlb_fully_assoc_fifo_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [0:0]                   op,
  input  logic [tlbfa_pkg::PROC_W-1:0]  process_id,
  input  logic [tlbfa_pkg::PAGE_W-1:0]  page_number,
  input  logic [tlbfa_pkg::FRAME_W-1:0] frame_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [tlbfa_pkg::FRAME_W-1:0] frame_out,
  output logic [tlbfa_pkg::SLOT_W-1:0]  slot_written
);

  localparam int unsigned PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(ENTRIES - 1);

  logic                         accept;
  logic                         is_fill;
  logic                         busy;
  logic [PTR_W-1:0]             fill_ptr;
  logic [PTR_W-1:0]             fill_ptr_next;
  logic [tlbfa_pkg::PROC_W-1:0]  key_process;
  logic [tlbfa_pkg::PAGE_W-1:0]  key_page;
  logic [ENTRIES-1:0]           wr_en;
  tlbfa_pkg::link_t             link [ENTRIES+1];

  assign is_fill  = (op == tlbfa_pkg::OP_FILL);
  assign in_ready = !busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign fill_ptr_next = (fill_ptr == LAST_SLOT) ? '0 : fill_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_ptr <= '0;
    end else if (accept && is_fill) begin
      fill_ptr <= fill_ptr_next;
    end
  end

  // Hold the lookup key for the whole walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_process <= process_id;
      key_page    <= page_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && !is_fill) begin
      busy <= 1'b1;
    end else if (link[ENTRIES].tok) begin
      busy <= 1'b0;
    end
  end

  // Inject the lookup token at the head of the row.
  always_ff @(posedge clk) begin
    link[0].hit   <= 1'b0;
    link[0].frame <= '0;
    if (rst) begin
      link[0].tok <= 1'b0;
    end else begin
      link[0].tok <= accept && !is_fill;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign wr_en[i] = accept && is_fill && (fill_ptr == PTR_W'(i));

    tlbfa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .wr_en      (wr_en[i]),
      .wr_process (process_id),
      .wr_page    (page_number),
      .wr_frame   (frame_in),
      .key_process(key_process),
      .key_page   (key_page),
      .link_in    (link[i]),
      .link_out   (link[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && is_fill) || link[ENTRIES].tok) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_fill) begin
      hit          <= 1'b0;
      frame_out    <= '0;
      slot_written <= tlbfa_pkg::SLOT_W'(fill_ptr);
    end else if (link[ENTRIES].tok) begin
      hit          <= link[ENTRIES].hit;
      frame_out    <= link[ENTRIES].hit ? link[ENTRIES].frame : '0;
      slot_written <= '0;
    end
  end

  `TLBFA_ASSERT_NOW(a_tok_only_busy, link[ENTRIES].tok, busy, "token left row while idle")
  `TLBFA_ASSERT_NEXT(a_lookup_busy, accept && !is_fill, busy, "lookup accepted but not busy")
  `TLBFA_ASSERT_NOW(a_one_write, 1'b1, $onehot0(wr_en), "more than one cell written")
  `TLBFA_ASSERT_NEXT(a_fill_out, accept && is_fill, out_valid && !hit && ~|frame_out, "bad fill")
  `TLBFA_ASSERT_NOW(a_ptr_range, 1'b1, fill_ptr <= LAST_SLOT, "fill pointer out of range")

endmodule
